// ----- src/assert_macros.svh -----
// Assertion macros shared by the classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a condition implies another in the same cycle outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/hsvc_pkg.sv -----
// Types and constants shared by the HSV threshold colour classifier.
package hsvc_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 17;
	localparam int BOUND_W    = 9;
	localparam int TENTHS_W   = 4;
	localparam int SAT_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [HUE_W-1:0]    hue_t;
	typedef logic [BOUND_W-1:0]  bound_t;
	typedef logic [TENTHS_W-1:0] tenths_t;
	typedef logic [SAT_W-1:0]    sat_t;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef enum logic [2:0] {
		CLASS_PASS,
		CLASS_RED,
		CLASS_GREEN,
		CLASS_BLUE,
		CLASS_BLACK
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAT_TENTHS,
		CFG_RED_VALUE_MIN,
		CFG_GREEN_VALUE_MIN,
		CFG_BLUE_VALUE_MIN,
		CFG_RED_HUE_UPPER_START,
		CFG_RED_HUE_LOWER_END,
		CFG_GREEN_HUE_START,
		CFG_GREEN_HUE_END
	} cfg_idx_t;

	localparam bound_t HUE_BLUE_LO = 9'd190;
	localparam bound_t HUE_BLUE_HI = 9'd290;
	localparam chan_t  FULL_ON     = 8'd255;

	localparam tenths_t RST_SAT_TENTHS     = 4'd3;
	localparam chan_t   RST_RED_VALUE_MIN  = 8'd80;
	localparam chan_t   RST_GREEN_VALUE_MIN = 8'd60;
	localparam chan_t   RST_BLUE_VALUE_MIN = 8'd80;
	localparam bound_t  RST_RED_HUE_UPPER  = 9'd350;
	localparam bound_t  RST_RED_HUE_LOWER  = 9'd20;
	localparam bound_t  RST_GREEN_HUE_START = 9'd70;
	localparam bound_t  RST_GREEN_HUE_END  = 9'd170;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

	typedef struct packed {
		tenths_t saturation_tenths;
		chan_t   red_value_min;
		chan_t   green_value_min;
		chan_t   blue_value_min;
		bound_t  red_hue_upper_start;
		bound_t  red_hue_lower_end;
		bound_t  green_hue_start;
		bound_t  green_hue_end;
	} cfg_t;

	typedef struct packed {
		pix_t    pix;
		chan_t   mx;
		chan_t   delta;
		sector_t sector;
	} ext_t;

	typedef struct packed {
		pix_t  pix;
		chan_t mx;
		chan_t delta;
		hue_t  hn;
		logic  saturated;
	} hue_stage_t;

endpackage

// ----- src/hsvc_extrema.sv -----
// First pipeline stage: channel maximum, minimum, delta and hue sector.
`include "assert_macros.svh"

module hsvc_extrema (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_stall,
	input  hsvc_pkg::pix_t pix,
	output logic           valid_s1,
	input  logic           down_stall,
	output hsvc_pkg::ext_t ext_s1
);
	import hsvc_pkg::*;

	chan_t   mx;
	chan_t   mn;
	sector_t sector;

	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		if (mx == pix.red) begin
			sector = SECT_RED;
		end else if (mx == pix.green) begin
			sector = SECT_GREEN;
		end else begin
			sector = SECT_BLUE;
		end
	end

	assign up_stall = valid_s1 && down_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			ext_s1.pix    <= pix;
			ext_s1.mx     <= mx;
			ext_s1.delta  <= mx - mn;
			ext_s1.sector <= sector;
		end
	end

	`ASSERT_IMPLIES(a_extrema_red_sector, valid_s1 && ext_s1.sector == SECT_RED, ext_s1.mx == ext_s1.pix.red, "Red sector chosen although red is not the maximum.")

endmodule

// ----- src/hsvc_hue.sv -----
// Second pipeline stage: hue numerator and saturation test.
`include "assert_macros.svh"

module hsvc_hue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  hsvc_pkg::ext_t       ext_in,
	input  hsvc_pkg::tenths_t    saturation_tenths,
	output logic                 valid_s2,
	input  logic                 down_stall,
	output hsvc_pkg::hue_stage_t hue_s2
);
	import hsvc_pkg::*;

	chan_t p;
	chan_t q;
	chan_t diff_mag;
	hue_t  scaled;
	hue_t  base;
	hue_t  hn;
	logic  saturated;

	always_comb begin
		case (ext_in.sector)
			SECT_RED: begin
				p = ext_in.pix.green;
				q = ext_in.pix.blue;
			end
			SECT_GREEN: begin
				p = ext_in.pix.blue;
				q = ext_in.pix.red;
			end
			SECT_BLUE: begin
				p = ext_in.pix.red;
				q = ext_in.pix.green;
			end
			default: begin
				p = ext_in.pix.red;
				q = ext_in.pix.green;
			end
		endcase
		diff_mag = (p >= q) ? (p - q) : (q - p);
		scaled = hue_t'(diff_mag) * hue_t'(60);
		case (ext_in.sector)
			SECT_RED:   base = (p < q) ? hue_t'(ext_in.delta) * hue_t'(360) : '0;
			SECT_GREEN: base = hue_t'(ext_in.delta) * hue_t'(120);
			SECT_BLUE:  base = hue_t'(ext_in.delta) * hue_t'(240);
			default:    base = '0;
		endcase
		hn = (p >= q) ? (base + scaled) : (base - scaled);
		saturated = (sat_t'(ext_in.delta) * sat_t'(10)) >
			(sat_t'(saturation_tenths) * sat_t'(ext_in.mx));
	end

	assign up_stall = valid_s2 && down_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!up_stall) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			hue_s2.pix       <= ext_in.pix;
			hue_s2.mx        <= ext_in.mx;
			hue_s2.delta     <= ext_in.delta;
			hue_s2.hn        <= hn;
			hue_s2.saturated <= saturated;
		end
	end

	`ASSERT_IMPLIES(a_hue_in_range, valid_s2, hue_s2.hn <= hue_t'(hue_s2.delta) * hue_t'(360), "Hue numerator exceeds a full turn.")

endmodule

// ----- src/hsvc_window.sv -----
// Third and fourth pipeline stages: window bound products and classification.
`include "assert_macros.svh"

module hsvc_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  hsvc_pkg::hue_stage_t hue_in,
	input  hsvc_pkg::cfg_t       cfg,
	output logic                 valid_s4,
	input  logic                 down_stall,
	output hsvc_pkg::pix_t       result_s4,
	output hsvc_pkg::class_t     class_s4
);
	import hsvc_pkg::*;

	typedef struct packed {
		pix_t  pix;
		chan_t mx;
		hue_t  hn;
		logic  saturated;
		hue_t  red_hi;
		hue_t  red_lo;
		hue_t  green_lo;
		hue_t  green_hi;
		hue_t  blue_lo;
		hue_t  blue_hi;
	} prod_t;

	logic   valid_s3;
	logic   stall_s3;
	prod_t  prod_s3;
	logic   red_hit;
	logic   green_hit;
	logic   blue_hit;
	pix_t   result;
	class_t cls;

	assign stall_s3 = valid_s4 && down_stall;
	assign up_stall = valid_s3 && stall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!up_stall) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			prod_s3.pix       <= hue_in.pix;
			prod_s3.mx        <= hue_in.mx;
			prod_s3.hn        <= hue_in.hn;
			prod_s3.saturated <= hue_in.saturated;
			prod_s3.red_hi    <= hue_t'(cfg.red_hue_upper_start) * hue_t'(hue_in.delta);
			prod_s3.red_lo    <= hue_t'(cfg.red_hue_lower_end) * hue_t'(hue_in.delta);
			prod_s3.green_lo  <= hue_t'(cfg.green_hue_start) * hue_t'(hue_in.delta);
			prod_s3.green_hi  <= hue_t'(cfg.green_hue_end) * hue_t'(hue_in.delta);
			prod_s3.blue_lo   <= hue_t'(HUE_BLUE_LO) * hue_t'(hue_in.delta);
			prod_s3.blue_hi   <= hue_t'(HUE_BLUE_HI) * hue_t'(hue_in.delta);
		end
	end

	always_comb begin
		red_hit = ((prod_s3.hn > prod_s3.red_hi) || (prod_s3.hn < prod_s3.red_lo)) &&
			(prod_s3.mx > cfg.red_value_min);
		green_hit = (prod_s3.hn > prod_s3.green_lo) && (prod_s3.hn < prod_s3.green_hi) &&
			(prod_s3.mx > cfg.green_value_min);
		blue_hit = (prod_s3.hn > prod_s3.blue_lo) && (prod_s3.hn < prod_s3.blue_hi) &&
			(prod_s3.mx > cfg.blue_value_min);
		result = '0;
		if (!prod_s3.saturated) begin
			result = prod_s3.pix;
			cls = CLASS_PASS;
		end else if (red_hit) begin
			result.red = FULL_ON;
			cls = CLASS_RED;
		end else if (green_hit) begin
			result.green = FULL_ON;
			cls = CLASS_GREEN;
		end else if (blue_hit) begin
			result.blue = FULL_ON;
			cls = CLASS_BLUE;
		end else begin
			cls = CLASS_BLACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (!stall_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && !stall_s3) begin
			result_s4 <= result;
			class_s4  <= cls;
		end
	end

	`ASSERT_CHECK(a_window_black, !(valid_s4 && class_s4 == CLASS_BLACK) || result_s4 == '0, "Unmatched saturated pixel is not black.")

endmodule

// ----- src/hsv_threshold_color_classifier.sv -----
// Top level of the HSV threshold colour classifier.
//
// One RGB pixel enters on the input channel (in_valid, in_stall) and one
// pixel with a class code leaves on the output channel (out_valid,
// out_stall). A request is taken at a clock edge where valid is high and
// stall is low.
// The block is a four-stage pipeline: extrema, hue and saturation, window
// bound products, classification. The result is registered at the end of
// each stage in that order, and one pixel is accepted every cycle while
// in_stall is low; each stage holds one register of logic, so the rate is
// one pixel per clock when no stall holds the flow.
// Every stage has its own valid bit, so bubbles close up and the block keeps
// accepting while a finished result waits at the output.
// When the receiver stalls, the result stays on the output ports unchanged;
// the stall reaches the input only once every stage ahead holds a pixel.
// Reset clears all valid bits and loads the registers with their defaults.
// Registers are written through cfg_write, cfg_index and cfg_data, and must
// only be written while no pixel is in flight.
module hsv_threshold_color_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [hsvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsvc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_red,
	input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_green,
	input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_blue,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [hsvc_pkg::CHAN_W-1:0]      result_red,
	output logic [hsvc_pkg::CHAN_W-1:0]      result_green,
	output logic [hsvc_pkg::CHAN_W-1:0]      result_blue,
	output logic [2:0]                       color_class
);
	import hsvc_pkg::*;

	cfg_t       cfg_q;
	pix_t       pix_in;
	logic       valid_s1;
	logic       stall_s1;
	ext_t       ext_s1;
	logic       valid_s2;
	logic       stall_s2;
	hue_stage_t hue_s2;
	pix_t       result_s4;
	class_t     class_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.saturation_tenths   <= RST_SAT_TENTHS;
			cfg_q.red_value_min       <= RST_RED_VALUE_MIN;
			cfg_q.green_value_min     <= RST_GREEN_VALUE_MIN;
			cfg_q.blue_value_min      <= RST_BLUE_VALUE_MIN;
			cfg_q.red_hue_upper_start <= RST_RED_HUE_UPPER;
			cfg_q.red_hue_lower_end   <= RST_RED_HUE_LOWER;
			cfg_q.green_hue_start     <= RST_GREEN_HUE_START;
			cfg_q.green_hue_end       <= RST_GREEN_HUE_END;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SAT_TENTHS:          cfg_q.saturation_tenths   <= cfg_data[TENTHS_W-1:0];
				CFG_RED_VALUE_MIN:       cfg_q.red_value_min       <= cfg_data[CHAN_W-1:0];
				CFG_GREEN_VALUE_MIN:     cfg_q.green_value_min     <= cfg_data[CHAN_W-1:0];
				CFG_BLUE_VALUE_MIN:      cfg_q.blue_value_min      <= cfg_data[CHAN_W-1:0];
				CFG_RED_HUE_UPPER_START: cfg_q.red_hue_upper_start <= cfg_data[BOUND_W-1:0];
				CFG_RED_HUE_LOWER_END:   cfg_q.red_hue_lower_end   <= cfg_data[BOUND_W-1:0];
				CFG_GREEN_HUE_START:     cfg_q.green_hue_start     <= cfg_data[BOUND_W-1:0];
				CFG_GREEN_HUE_END:       cfg_q.green_hue_end       <= cfg_data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pix_in.red   = pixel_red;
	assign pix_in.green = pixel_green;
	assign pix_in.blue  = pixel_blue;

	hsvc_extrema u_extrema (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_stall   (in_stall),
		.pix        (pix_in),
		.valid_s1   (valid_s1),
		.down_stall (stall_s1),
		.ext_s1     (ext_s1)
	);

	hsvc_hue u_hue (
		.clk               (clk),
		.arst_n            (arst_n),
		.up_valid          (valid_s1),
		.up_stall          (stall_s1),
		.ext_in            (ext_s1),
		.saturation_tenths (cfg_q.saturation_tenths),
		.valid_s2          (valid_s2),
		.down_stall        (stall_s2),
		.hue_s2            (hue_s2)
	);

	hsvc_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s2),
		.up_stall   (stall_s2),
		.hue_in     (hue_s2),
		.cfg        (cfg_q),
		.valid_s4   (out_valid),
		.down_stall (out_stall),
		.result_s4  (result_s4),
		.class_s4   (class_s4)
	);

	assign result_red   = result_s4.red;
	assign result_green = result_s4.green;
	assign result_blue  = result_s4.blue;
	assign color_class  = class_s4;

endmodule

// ----- verif/tb_hsv_threshold_color_classifier.sv -----
// Self-checking testbench for the HSV threshold colour classifier with a built-in predictor.
`timescale 1ns / 1ps

module tb_hsv_threshold_color_classifier;
	import hsvc_pkg::*;

	typedef struct packed {
		chan_t  red;
		chan_t  green;
		chan_t  blue;
		class_t cls;
	} classified_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [CHAN_W-1:0]     pixel_red;
	logic [CHAN_W-1:0]     pixel_green;
	logic [CHAN_W-1:0]     pixel_blue;
	logic                  out_valid;
	logic                  out_stall;
	logic [CHAN_W-1:0]     result_red;
	logic [CHAN_W-1:0]     result_green;
	logic [CHAN_W-1:0]     result_blue;
	logic [2:0]            color_class;

	tenths_t reg_sat_tenths;
	chan_t   reg_red_value_min;
	chan_t   reg_green_value_min;
	chan_t   reg_blue_value_min;
	bound_t  reg_red_hue_upper;
	bound_t  reg_red_hue_lower;
	bound_t  reg_green_hue_start;
	bound_t  reg_green_hue_end;

	classified_t predicted_pixels[$];
	int          fail_count;
	int          hold_off_cycles;
	int          sink_burst_left;
	bit          src_idle_on;
	bit          sink_idle_on;

	hsv_threshold_color_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_red   (result_red),
		.result_green (result_green),
		.result_blue  (result_blue),
		.color_class  (color_class)
	);

	always #6 clk = ~clk;

	function automatic classified_t classify_pixel(chan_t r, chan_t g, chan_t b);
		int rv, gv, bv, mx, mn, d, hn;
		classified_t res;
		rv = int'(r);
		gv = int'(g);
		bv = int'(b);
		mx = rv;
		mn = rv;
		if (gv > mx) mx = gv;
		if (bv > mx) mx = bv;
		if (gv < mn) mn = gv;
		if (bv < mn) mn = bv;
		d = mx - mn;
		res.red = r;
		res.green = g;
		res.blue = b;
		res.cls = CLASS_PASS;
		if (d == 0 || !(10 * d > int'(reg_sat_tenths) * mx))
			return res;
		if (mx == rv)
			hn = 60 * (gv - bv);
		else if (mx == gv)
			hn = 120 * d + 60 * (bv - rv);
		else
			hn = 240 * d + 60 * (rv - gv);
		if (hn < 0)
			hn += 360 * d;
		res.red = '0;
		res.green = '0;
		res.blue = '0;
		if ((hn > int'(reg_red_hue_upper) * d || hn < int'(reg_red_hue_lower) * d) &&
				mx > int'(reg_red_value_min)) begin
			res.red = FULL_ON;
			res.cls = CLASS_RED;
		end else if (hn > int'(reg_green_hue_start) * d && hn < int'(reg_green_hue_end) * d &&
				mx > int'(reg_green_value_min)) begin
			res.green = FULL_ON;
			res.cls = CLASS_GREEN;
		end else if (hn > int'(HUE_BLUE_LO) * d && hn < int'(HUE_BLUE_HI) * d &&
				mx > int'(reg_blue_value_min)) begin
			res.blue = FULL_ON;
			res.cls = CLASS_BLUE;
		end else begin
			res.cls = CLASS_BLACK;
		end
		return res;
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		chan_t top;
		top = chan_t'($urandom_range(40, 255));
		p.red = chan_t'($urandom_range(0, top));
		p.green = chan_t'($urandom_range(0, top));
		p.blue = chan_t'($urandom_range(0, top));
		case ($urandom_range(0, 4))
			0: p = pix_t'(24'($urandom));
			1: p.red = top;
			2: p.green = top;
			3: p.blue = top;
			default: begin
				p.red = top;
				p.green = top;
			end
		endcase
		return p;
	endfunction

	task automatic send_pixel(chan_t r, chan_t g, chan_t b);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_red <= r;
		pixel_green <= g;
		pixel_blue <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted_pixels.push_back(classify_pixel(r, g, b));
	endtask

	task automatic send_random(int count);
		pix_t p;
		repeat (count) begin
			p = random_pixel();
			send_pixel(p.red, p.green, p.blue);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (predicted_pixels.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		case (idx)
			CFG_SAT_TENTHS:          reg_sat_tenths = tenths_t'(value);
			CFG_RED_VALUE_MIN:       reg_red_value_min = chan_t'(value);
			CFG_GREEN_VALUE_MIN:     reg_green_value_min = chan_t'(value);
			CFG_BLUE_VALUE_MIN:      reg_blue_value_min = chan_t'(value);
			CFG_RED_HUE_UPPER_START: reg_red_hue_upper = bound_t'(value);
			CFG_RED_HUE_LOWER_END:   reg_red_hue_lower = bound_t'(value);
			CFG_GREEN_HUE_START:     reg_green_hue_start = bound_t'(value);
			CFG_GREEN_HUE_END:       reg_green_hue_end = bound_t'(value);
			default: ;
		endcase
	endtask

	task automatic apply_settings(int unsigned tenths, int unsigned rmin, int unsigned gmin,
			int unsigned bmin, int unsigned rup, int unsigned rlo, int unsigned gstart,
			int unsigned gend);
		wait_drained();
		write_register(CFG_SAT_TENTHS, tenths);
		write_register(CFG_RED_VALUE_MIN, rmin);
		write_register(CFG_GREEN_VALUE_MIN, gmin);
		write_register(CFG_BLUE_VALUE_MIN, bmin);
		write_register(CFG_RED_HUE_UPPER_START, rup);
		write_register(CFG_RED_HUE_LOWER_END, rlo);
		write_register(CFG_GREEN_HUE_START, gstart);
		write_register(CFG_GREEN_HUE_END, gend);
		cfg_write <= 1'b0;
	endtask

	task automatic test_directed_defaults();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd50, 8'd0, 8'd0);
		send_pixel(8'd80, 8'd0, 8'd0);
		send_pixel(8'd81, 8'd0, 8'd0);
		send_pixel(8'd200, 8'd180, 8'd190);
		send_pixel(8'd255, 8'd0, 8'd10);
		send_pixel(8'd255, 8'd85, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd255);
		send_pixel(8'hAA, 8'h55, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'h00);
		send_pixel(8'd100, 8'd70, 8'd70);
		send_pixel(8'd61, 8'd0, 8'd0);
	endtask

	task automatic test_register_extremes();
		apply_settings(0, 0, 0, 0, 0, 0, 0, 360);
		send_random(20);
		apply_settings(10, 255, 255, 255, 360, 360, 360, 360);
		send_random(20);
		apply_settings(15, 0, 0, 0, 511, 0, 0, 511);
		send_random(20);
		apply_settings(1, 255, 0, 0, 360, 0, 0, 0);
		send_random(20);
		apply_settings(0, 0, 255, 0, 511, 511, 511, 511);
		send_random(20);
		apply_settings(9, 10, 10, 10, 300, 60, 60, 200);
		send_random(20);
	endtask

	task automatic test_backpressure();
		apply_settings(RST_SAT_TENTHS, RST_RED_VALUE_MIN, RST_GREEN_VALUE_MIN,
			RST_BLUE_VALUE_MIN, RST_RED_HUE_UPPER, RST_RED_HUE_LOWER,
			RST_GREEN_HUE_START, RST_GREEN_HUE_END);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_off_cycles = 80;
		send_random(30);
		wait_drained();
		send_random(10);
	endtask

	task automatic test_random_settings();
		int unsigned lo;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (6) begin
			lo = $urandom_range(0, 250);
			apply_settings(($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 10),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(280, 360), $urandom_range(0, 60), lo,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(lo, 360));
			send_random(45);
		end
	endtask

	task automatic test_final_no_idle();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		apply_settings(RST_SAT_TENTHS, RST_RED_VALUE_MIN, RST_GREEN_VALUE_MIN,
			RST_BLUE_VALUE_MIN, RST_RED_HUE_UPPER, RST_RED_HUE_LOWER,
			RST_GREEN_HUE_START, RST_GREEN_HUE_END);
		send_random(30);
	endtask

	initial begin
		out_stall <= 1'b0;
		sink_burst_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				hold_off_cycles--;
			end else if (sink_burst_left > 0) begin
				out_stall <= 1'b1;
				sink_burst_left--;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				sink_burst_left = $urandom_range(0, 11);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		classified_t got;
		classified_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {result_red, result_green, result_blue, class_t'(color_class)};
			if (predicted_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result: r=%0d g=%0d b=%0d class=%0d",
						got.red, got.green, got.blue, got.cls);
			end else begin
				want = predicted_pixels.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mismatch: want %0d %0d %0d class %0d, got %0d %0d %0d class %0d",
							want.red, want.green, want.blue, want.cls,
							got.red, got.green, got.blue, got.cls);
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel_red <= '0;
		pixel_green <= '0;
		pixel_blue <= '0;
		fail_count = 0;
		hold_off_cycles = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		reg_sat_tenths = RST_SAT_TENTHS;
		reg_red_value_min = RST_RED_VALUE_MIN;
		reg_green_value_min = RST_GREEN_VALUE_MIN;
		reg_blue_value_min = RST_BLUE_VALUE_MIN;
		reg_red_hue_upper = RST_RED_HUE_UPPER;
		reg_red_hue_lower = RST_RED_HUE_LOWER;
		reg_green_hue_start = RST_GREEN_HUE_START;
		reg_green_hue_end = RST_GREEN_HUE_END;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_settings();
		test_final_no_idle();

		wait_drained();
		repeat (10) @(posedge clk);
		fail_count += predicted_pixels.size();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
